/* sv/sqi_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the key compare for the sorted insert queue.
package sqi_pkg;

  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             valid;
    logic             found;
  } cell_link_t;

  // true when key a orders strictly after key b
  function automatic logic key_greater(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b,
                                       input logic             sgn);
    logic [KEY_W-1:0] aa;
    logic [KEY_W-1:0] bb;
    aa = a ^ {sgn, {(KEY_W-1){1'b0}}};
    bb = b ^ {sgn, {(KEY_W-1){1'b0}}};
    return aa > bb;
  endfunction

endpackage

/* sv/sqi_in_if.sv */
`timescale 1ns / 1ps
// Input channel: operation and key with valid/ready handshake.
interface sqi_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [sqi_pkg::KEY_W-1:0]   key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

/* sv/sqi_out_if.sv */
`timescale 1ns / 1ps
// Result channel: popped key, status and store summary with valid/ready handshake.
interface sqi_out_if;
  logic                          valid;
  logic                          ready;
  logic [sqi_pkg::KEY_W-1:0]     popped_key;
  logic [1:0]                    status;
  logic [sqi_pkg::COUNT_W-1:0]   entry_count;
  logic [sqi_pkg::KEY_W-1:0]     front_key;
  logic [sqi_pkg::KEY_W-1:0]     back_key;
  logic                          is_empty;

  modport source (output valid, output popped_key, output status, output entry_count,
                  output front_key, output back_key, output is_empty, input ready);
  modport sink   (input valid, input popped_key, input status, input entry_count,
                  input front_key, input back_key, input is_empty, output ready);
endinterface

/* sv/sorted_insert_queue.sv */
`timescale 1ns / 1ps
// Sorted insert queue top level: chain of key cells, count, back key and result register.
// The result of an item is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle while the result side keeps taking results.
// The push position is found by a found-flag rippling through the cell chain.
// Reset (rst, synchronous): store empty, no result pending, compare_signed set to 1.
module sorted_insert_queue #(
  parameter int DEPTH = sqi_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  sqi_in_if.sink           in_ch,
  sqi_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                       compare_signed;
  logic [CNT_W-1:0]           count;
  logic [sqi_pkg::KEY_W-1:0]  back;

  sqi_pkg::cell_link_t        links [DEPTH];
  sqi_pkg::cell_link_t        lefts [DEPTH];
  sqi_pkg::cell_link_t        rights[DEPTH];
  logic [DEPTH-1:0]           gt_vec;

  logic                       accept;
  logic                       full;
  logic                       push_en;
  logic                       pop_en;
  logic                       any_gt;
  logic [CNT_W-1:0]           count_next;
  logic [sqi_pkg::KEY_W-1:0]  back_next;
  logic [sqi_pkg::KEY_W-1:0]  front_next;
  logic [1:0]                 status_next;
  logic [sqi_pkg::KEY_W-1:0]  popped_next;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count == CNT_W'(DEPTH));
  assign push_en     = accept && (in_ch.operation == sqi_pkg::OP_PUSH) && !full;
  assign pop_en      = accept && (in_ch.operation == sqi_pkg::OP_POP) && (count != '0);
  assign any_gt      = |gt_vec;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign lefts[i] = '0;
      end else begin : g_mid
        assign lefts[i] = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign rights[i] = '0;
      end else begin : g_inner
        assign rights[i] = links[i+1];
      end
      sqi_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .push_en        (push_en),
        .pop_en         (pop_en),
        .new_key        (in_ch.key),
        .compare_signed (compare_signed),
        .left           (lefts[i]),
        .right          (rights[i]),
        .link           (links[i]),
        .gt             (gt_vec[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    back_next   = back;
    front_next  = links[0].valid ? links[0].key : '0;
    status_next = sqi_pkg::ST_OK;
    popped_next = '0;
    if (in_ch.operation == sqi_pkg::OP_PUSH) begin
      if (full) begin
        status_next = sqi_pkg::ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
        if (!any_gt) begin
          back_next = in_ch.key;
        end
        if (!links[0].valid || gt_vec[0]) begin
          front_next = in_ch.key;
        end
      end
    end else begin
      if (count == '0) begin
        status_next = sqi_pkg::ST_EMPTY;
      end else begin
        count_next  = count - CNT_W'(1);
        popped_next = links[0].key;
        front_next  = links[1].valid ? links[1].key : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_signed <= 1'b1;
      count          <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        compare_signed <= cfg_wr_data;
      end
      if (accept) begin
        count        <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      back               <= back_next;
      out_ch.popped_key  <= popped_next;
      out_ch.status      <= status_next;
      out_ch.entry_count <= sqi_pkg::COUNT_W'(count_next);
      out_ch.front_key   <= (count_next == '0) ? '0 : front_next;
      out_ch.back_key    <= (count_next == '0) ? '0 : back_next;
      out_ch.is_empty    <= (count_next == '0);
    end
  end

endmodule

/* sv/sqi_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds a key, shifts right on push, left on pop.
module sqi_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_en,
  input  logic                       pop_en,
  input  logic [sqi_pkg::KEY_W-1:0]  new_key,
  input  logic                       compare_signed,
  input  sqi_pkg::cell_link_t        left,
  input  sqi_pkg::cell_link_t        right,
  output sqi_pkg::cell_link_t        link,
  output logic                       gt
);

  logic [sqi_pkg::KEY_W-1:0] key;
  logic                      valid;
  logic                      hit;

  assign gt   = valid && sqi_pkg::key_greater(key, new_key, compare_signed);
  assign hit  = gt || !valid;

  assign link.key   = key;
  assign link.valid = valid;
  assign link.found = left.found || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_en) begin
      if (left.found) begin
        valid <= left.valid;
      end else if (hit) begin
        valid <= 1'b1;
      end
    end else if (pop_en) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      if (left.found) begin
        key <= left.key;
      end else if (hit) begin
        key <= new_key;
      end
    end else if (pop_en) begin
      key <= right.key;
    end
  end

endmodule

/* sv/sqi_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the sorted insert queue, bound to the top level.
module sqi_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sqi_pkg::KEY_W-1:0]   popped_key,
  input logic [1:0]                  status,
  input logic [sqi_pkg::COUNT_W-1:0] entry_count,
  input logic [sqi_pkg::KEY_W-1:0]   front_key,
  input logic [sqi_pkg::KEY_W-1:0]   back_key,
  input logic                        is_empty
);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_empty_keys: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (front_key == '0 && back_key == '0))
    else $error("empty store reports nonzero keys");

  a_refused_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sqi_pkg::ST_EMPTY) |-> (is_empty && popped_key == '0))
    else $error("refused pop reports data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == sqi_pkg::ST_OK || status == sqi_pkg::ST_FULL ||
                   status == sqi_pkg::ST_EMPTY))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(popped_key) && $stable(status)
                                   && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind sorted_insert_queue sqi_checker u_sqi_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .popped_key  (out_ch.popped_key),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count),
  .front_key   (out_ch.front_key),
  .back_key    (out_ch.back_key),
  .is_empty    (out_ch.is_empty)
);

/* sim/tb_sorted_insert_queue.sv */
`timescale 1ns / 1ps
// Testbench for sorted_insert_queue: shadow sorted store, paced handshakes, per-result field checks.
module tb_sorted_insert_queue;

  localparam int DEPTH = sqi_pkg::DEPTH_DEF;

  typedef struct packed {
    logic                      operation;
    logic [sqi_pkg::KEY_W-1:0] key;
  } queue_op_t;

  typedef struct packed {
    logic [sqi_pkg::KEY_W-1:0]   popped_key;
    logic [1:0]                  status;
    logic [sqi_pkg::COUNT_W-1:0] entry_count;
    logic [sqi_pkg::KEY_W-1:0]   front_key;
    logic [sqi_pkg::KEY_W-1:0]   back_key;
    logic                        is_empty;
  } queue_result_t;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_style_t;

  int        gap_plan [6] = '{0, 6, 0, 3, 8, 2};
  rx_style_t rx_plan [6] = '{RX_STEADY, RX_RANDOM, RX_RANDOM,
                             RX_PATTERN, RX_RANDOM, RX_PATTERN};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  logic                      drv_valid = 1'b0;
  logic                      drv_op = sqi_pkg::OP_PUSH;
  logic [sqi_pkg::KEY_W-1:0] drv_key = '0;
  logic                      rx_ready = 1'b0;
  logic                      op_taken = 1'b0;

  sqi_in_if  in_bus ();
  sqi_out_if out_bus ();

  assign in_bus.valid     = drv_valid;
  assign in_bus.operation = drv_op;
  assign in_bus.key       = drv_key;
  assign out_bus.ready    = rx_ready;

  sorted_insert_queue u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_bus),
    .out_ch      (out_bus)
  );

  queue_op_t     pending_ops [$];
  queue_result_t outcome_q [$];

  logic [sqi_pkg::KEY_W-1:0] shadow_keys [DEPTH];
  int                        shadow_count = 0;
  logic                      order_signed = 1'b1;

  int ops_queued = 0;
  int order_changes = 0;
  int mismatch_count = 0;
  int n_stored = 0;
  int n_popped = 0;
  int n_full = 0;
  int n_empty = 0;

  int        tx_gap_max = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  rx_style_t rx_mode = RX_STEADY;
  int        rx_tick = 0;
  int        rx_hold_len = 0;
  int        rx_hold_seq = 0;
  int        rx_hold_seen = 0;
  int        rx_hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic ranks_after(input logic [sqi_pkg::KEY_W-1:0] a,
                                       input logic [sqi_pkg::KEY_W-1:0] b);
    if (order_signed) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic queue_result_t apply_queue_op(input queue_op_t op);
    queue_result_t r;
    int slot;
    r = '0;
    if (op.operation == sqi_pkg::OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.status = sqi_pkg::ST_FULL;
      end else begin
        slot = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
          if (ranks_after(shadow_keys[i], op.key)) begin
            slot = i;
            break;
          end
        end
        for (int i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[slot] = op.key;
        shadow_count++;
        r.status = sqi_pkg::ST_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = sqi_pkg::ST_EMPTY;
      end else begin
        r.popped_key = shadow_keys[0];
        for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
        shadow_count--;
        r.status = sqi_pkg::ST_OK;
      end
    end
    r.entry_count = sqi_pkg::COUNT_W'(shadow_count);
    r.front_key   = (shadow_count != 0) ? shadow_keys[0] : '0;
    r.back_key    = (shadow_count != 0) ? shadow_keys[shadow_count-1] : '0;
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  function automatic logic [sqi_pkg::KEY_W-1:0] rand_key();
    logic [sqi_pkg::KEY_W-1:0] low;
    low = sqi_pkg::KEY_W'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return low;
      2: return 32'hFFFF_FFF0 | low;
      3: return 32'h8000_0000 | low;
      4: return 32'h7FFF_FFF0 | low;
      default: return $urandom_range(0, 1) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                            : sqi_pkg::KEY_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_op(input logic op, input logic [sqi_pkg::KEY_W-1:0] k);
    queue_op_t item;
    item.operation = op;
    item.key = k;
    pending_ops.push_back(item);
    ops_queued++;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_ops.size() != 0 || drv_valid || outcome_q.size() != 0);
  endtask

  task automatic set_order(input logic s);
    wait_drained();
    repeat (2) @(negedge clk);
    if (s != order_signed) order_changes++;
    cfg_wr_data <= s;
    cfg_wr_en <= 1'b1;
    order_signed = s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(negedge clk) begin : drive_ops
    queue_op_t nxt;
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !op_taken) begin
      // hold until the transfer happens
    end else if (gap_left != 0) begin
      drv_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_ops.size() != 0) begin
      nxt = pending_ops.pop_front();
      drv_valid <= 1'b1;
      drv_op <= nxt.operation;
      drv_key <= nxt.key;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // receiver: stall pattern plus requested long hold-offs
  always @(negedge clk) begin : pace_results
    rx_tick <= rx_tick + 1;
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= rx_hold_len;
      rx_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      rx_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  rx_ready <= ($urandom_range(0, 99) < 65);
        RX_PATTERN: rx_ready <= ((rx_tick % 11) > 3);
        default:    rx_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : watch_channels
    queue_result_t got;
    queue_result_t want;
    queue_op_t     seen;
    op_taken <= in_bus.valid && in_bus.ready;
    if (!rst) begin
      if (out_bus.valid && out_bus.ready) begin
        got.popped_key  = out_bus.popped_key;
        got.status      = out_bus.status;
        got.entry_count = out_bus.entry_count;
        got.front_key   = out_bus.front_key;
        got.back_key    = out_bus.back_key;
        got.is_empty    = out_bus.is_empty;
        if (outcome_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%t unexpected result: pop=%h st=%0d cnt=%0d front=%h back=%h empty=%b",
                     $realtime, got.popped_key, got.status, got.entry_count, got.front_key,
                     got.back_key, got.is_empty);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          if (got.popped_key !== want.popped_key || got.status !== want.status ||
              got.entry_count !== want.entry_count || got.front_key !== want.front_key ||
              got.back_key !== want.back_key || got.is_empty !== want.is_empty) begin
            if (mismatch_count < 10) begin
              $display("%t mismatch expected: pop=%h st=%0d cnt=%0d front=%h back=%h empty=%b",
                       $realtime, want.popped_key, want.status, want.entry_count,
                       want.front_key, want.back_key, want.is_empty);
              $display("%t          actual:   pop=%h st=%0d cnt=%0d front=%h back=%h empty=%b",
                       $realtime, got.popped_key, got.status, got.entry_count,
                       got.front_key, got.back_key, got.is_empty);
            end
            mismatch_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        seen.operation = in_bus.operation;
        seen.key = in_bus.key;
        want = apply_queue_op(seen);
        outcome_q.push_back(want);
        if (want.status == sqi_pkg::ST_FULL) n_full++;
        else if (want.status == sqi_pkg::ST_EMPTY) n_empty++;
        else if (seen.operation == sqi_pkg::OP_PUSH) n_stored++;
        else n_popped++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_phases
    int phase_start;
    int n;
    int bias;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    set_order(1'b1);
    queue_op(sqi_pkg::OP_POP, 32'hFFFF_FFFF);
    queue_op(sqi_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_op(sqi_pkg::OP_PUSH, 32'h8000_0000);
    queue_op(sqi_pkg::OP_PUSH, 32'h0000_0000);
    queue_op(sqi_pkg::OP_PUSH, 32'hFFFF_FFFF);
    queue_op(sqi_pkg::OP_PUSH, 32'h0000_0001);
    queue_op(sqi_pkg::OP_PUSH, 32'h0000_0001);
    repeat (7) queue_op(sqi_pkg::OP_POP, 32'h0000_0000);
    queue_op(sqi_pkg::OP_PUSH, 32'hFFFF_FFFF);
    queue_op(sqi_pkg::OP_PUSH, 32'h0000_0005);

    // flip the order with keys still stored
    set_order(1'b0);
    queue_op(sqi_pkg::OP_PUSH, 32'h0000_0007);
    queue_op(sqi_pkg::OP_PUSH, 32'h8000_0000);
    repeat (5) queue_op(sqi_pkg::OP_POP, 32'h5555_AAAA);

    for (int p = 0; p < 6; p++) begin
      set_order((p % 2) == 0);
      tx_gap_max = gap_plan[p];
      rx_mode = rx_plan[p];
      if (p == 2) begin
        rx_hold_len = 120;
        rx_hold_seq = rx_hold_seq + 1;
      end
      phase_start = ops_queued;
      while (ops_queued - phase_start < 300) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat (DEPTH + 2) queue_op(sqi_pkg::OP_PUSH, rand_key());
          repeat (DEPTH + 2) queue_op(sqi_pkg::OP_POP, rand_key());
        end else begin
          n = $urandom_range(10, 40);
          bias = $urandom_range(30, 70);
          repeat (n) queue_op(($urandom_range(0, 99) < bias) ? sqi_pkg::OP_PUSH
                                                            : sqi_pkg::OP_POP, rand_key());
        end
      end
      // leave keys stored across the next order write
      repeat (3) queue_op(sqi_pkg::OP_PUSH, rand_key());
    end

    wait_drained();
    repeat (5) @(negedge clk);
    if (outcome_q.size() != 0) mismatch_count += outcome_q.size();
    $display("Ran %0d items under both key orders (%0d order flips): %0d pushes stored, %0d pops,",
             ops_queued, order_changes, n_stored, n_popped);
    $display("%0d pushes refused on a full store, %0d pops refused on an empty store, %0d errors.",
             n_full, n_empty, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
